// ===== hdl/lgbe_pkg.sv =====
// Shared types and constants for the life generation byte engine.
package lgbe_pkg;

  localparam int unsigned ROWS_PER_PAGE = 8;
  localparam int unsigned VEC_W         = ROWS_PER_PAGE + 2;
  localparam int unsigned CNT_W         = 4;

  typedef logic [ROWS_PER_PAGE-1:0] byte_t;
  typedef logic [VEC_W-1:0]         col_vec_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef cnt_t [ROWS_PER_PAGE-1:0] cnt_vec_t;

  typedef enum logic [1:0] {
    KIND_FRAME_WR = 2'd0,
    KIND_COMPUTE  = 2'd1,
    KIND_NEXT_WR  = 2'd2
  } kind_e;

  // Offsets within the 3x3 byte neighbourhood
  localparam logic [1:0] OFS_LOW  = 2'd0;
  localparam logic [1:0] OFS_MID  = 2'd1;
  localparam logic [1:0] OFS_HIGH = 2'd2;

  typedef struct packed {
    logic clr;
    logic add;
    logic centre;
  } cnt_ctrl_t;

endpackage

// ===== hdl/lgbe_ram.sv =====
// Single-port-write, single-port-read byte store with registered read data.
module lgbe_ram import lgbe_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  byte_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output byte_t         rdata_o
);

  byte_t mem_q [DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lgbe_count_unit.sv =====
// Neighbour counter: accumulates one column window per beat into eight cell counts.
module lgbe_count_unit import lgbe_pkg::*; (
  input  logic      clk_i,
  input  cnt_ctrl_t ctrl_i,
  input  col_vec_t  vec_i,
  output cnt_vec_t  cnt_o
);

  cnt_vec_t cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end else if (ctrl_i.add) begin
      for (int n = 0; n < ROWS_PER_PAGE; n++) begin
        // vec bit n+1 is the cell itself in the centre column: drop it
        cnt_d[n] = cnt_q[n] + CNT_W'(vec_i[n]) + CNT_W'(vec_i[n+2])
                 + CNT_W'(vec_i[n+1] & ~ctrl_i.centre);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
  end

  assign cnt_o = cnt_q;

endmodule

// ===== hdl/life_generation_byte_engine.sv =====
// Top level: Game of Life (B3/S23) byte engine over a page-organised frame.
//
// A write item (frame or next-generation byte) is taken while idle and
// busy stays low. A compute item holds busy through the fetch, drain and
// apply states, and its result is strobed for one cycle when busy is
// already low again; the frame store has one read port, and the nine frame
// bytes around the target are fetched through it one per cycle while a
// shared counter folds each finished column into the eight cell counts.
// Items naming a page or column outside the frame, and the unused kind, are
// dropped without effect. After reset both stores are swept to zero, one
// entry a cycle, with busy high until the sweep is done. The receiver cannot
// stall: each result beat lasts exactly one cycle.
module life_generation_byte_engine import lgbe_pkg::*; #(
  parameter int unsigned FRAME_COLUMNS = 128,
  parameter int unsigned FRAME_PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind_i,
  input  logic [2:0] page_i,
  input  logic [6:0] column_i,
  input  logic [7:0] data_i,
  output logic       strobe_o,
  output logic [2:0] page_out_o,
  output logic [6:0] column_out_o,
  output logic [7:0] next_byte_o
);

  localparam int unsigned DEPTH = FRAME_PAGES * FRAME_COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(FRAME_PAGES);
  localparam int unsigned CW    = $clog2(FRAME_COLUMNS);
  localparam int unsigned PW1   = PW + 1;
  localparam int unsigned CW1   = CW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_APPLY
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic [PW-1:0]   page_q, page_d;
  logic [CW-1:0]   col_q, col_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [1:0]      dp_q, dp_d;
  logic [1:0]      dc_q, dc_d;
  logic            strobe_q, strobe_d;
  logic [2:0]      page_out_q, page_out_d;
  logic [6:0]      column_out_q, column_out_d;
  byte_t           next_byte_q, next_byte_d;

  // Read-side pipeline for the frame store
  logic            rd_pend_q;
  logic            rd_ok_q;
  logic [1:0]      rd_dp_q;
  logic [1:0]      rd_dc_q;
  logic [VEC_W-2:0] vec_q;
  byte_t           own_q;

  logic            accept;
  logic            in_range;
  logic [AW-1:0]   in_addr;
  kind_e           kind;

  logic [PW1-1:0]  nb_page;
  logic [CW1-1:0]  nb_col;
  logic            nb_ok;
  logic [AW-1:0]   fr_raddr;
  byte_t           fr_rdata;
  logic            fr_re;
  logic            fr_we;
  logic [AW-1:0]   fr_waddr;
  byte_t           fr_wdata;

  logic            ng_we;
  logic [AW-1:0]   ng_waddr;
  byte_t           ng_wdata;
  logic            ng_re;
  byte_t           ng_rdata;

  cnt_ctrl_t       cnt_ctrl;
  col_vec_t        col_vec;
  cnt_vec_t        cnt;
  byte_t           result;

  assign kind     = kind_e'(kind_i);
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(page_i) < FRAME_PAGES) && (32'(column_i) < FRAME_COLUMNS);
  assign in_addr  = AW'(32'(PW'(page_i)) * FRAME_COLUMNS + 32'(CW'(column_i)));

  // Neighbour address; underflow wraps to a value beyond the frame
  assign nb_page  = {1'b0, page_q} + PW1'(dp_q) - PW1'(1);
  assign nb_col   = {1'b0, col_q} + CW1'(dc_q) - CW1'(1);
  assign nb_ok    = (32'(nb_page) < FRAME_PAGES) && (32'(nb_col) < FRAME_COLUMNS);
  assign fr_raddr = AW'(32'(nb_page[PW-1:0]) * FRAME_COLUMNS + 32'(nb_col[CW-1:0]));
  assign fr_re    = (state_q == ST_FETCH) && nb_ok;

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = in_addr;
    fr_wdata = data_i;
    ng_we    = 1'b0;
    ng_waddr = in_addr;
    ng_wdata = data_i;
    priority if (state_q == ST_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = clr_addr_q;
      fr_wdata = '0;
      ng_we    = 1'b1;
      ng_waddr = clr_addr_q;
      ng_wdata = '0;
    end else if (state_q == ST_APPLY) begin
      ng_we    = 1'b1;
      ng_waddr = addr_q;
      ng_wdata = result;
    end else if (accept && in_range) begin
      fr_we = (kind == KIND_FRAME_WR);
      ng_we = (kind == KIND_NEXT_WR);
    end
  end

  assign ng_re = accept && in_range && (kind == KIND_COMPUTE);

  lgbe_ram #(.DEPTH(DEPTH), .AW(AW)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  lgbe_ram #(.DEPTH(DEPTH), .AW(AW)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (ng_we),
    .waddr_i (ng_waddr),
    .wdata_i (ng_wdata),
    .re_i    (ng_re),
    .raddr_i (in_addr),
    .rdata_o (ng_rdata)
  );

  // Complete column window when the byte below arrives
  assign col_vec = {rd_ok_q & fr_rdata[0], vec_q};

  assign cnt_ctrl.clr    = ng_re;
  assign cnt_ctrl.add    = rd_pend_q && (rd_dp_q == OFS_HIGH);
  assign cnt_ctrl.centre = (rd_dc_q == OFS_MID);

  lgbe_count_unit u_count (
    .clk_i  (clk_i),
    .ctrl_i (cnt_ctrl),
    .vec_i  (col_vec),
    .cnt_o  (cnt)
  );

  // B3/S23; survivors and untouched cells keep the stored next-generation bit
  always_comb begin
    for (int n = 0; n < ROWS_PER_PAGE; n++) begin
      if (own_q[n]) begin
        result[n] = ((cnt[n] == CNT_W'(2)) || (cnt[n] == CNT_W'(3))) ? ng_rdata[n] : 1'b0;
      end else begin
        result[n] = (cnt[n] == CNT_W'(3)) ? 1'b1 : ng_rdata[n];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_FETCH);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= nb_ok;
    rd_dp_q <= dp_q;
    rd_dc_q <= dc_q;
    if (rd_pend_q) begin
      unique case (rd_dp_q)
        OFS_LOW: vec_q[0] <= rd_ok_q & fr_rdata[ROWS_PER_PAGE-1];
        OFS_MID: begin
          vec_q[VEC_W-2:1] <= rd_ok_q ? fr_rdata : '0;
          if (rd_dc_q == OFS_MID) begin
            own_q <= rd_ok_q ? fr_rdata : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    page_d       = page_q;
    col_d        = col_q;
    addr_d       = addr_q;
    dp_d         = dp_q;
    dc_d         = dc_q;
    strobe_d     = 1'b0;
    page_out_d   = page_out_q;
    column_out_d = column_out_q;
    next_byte_d  = next_byte_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ng_re) begin
          page_d  = PW'(page_i);
          col_d   = CW'(column_i);
          addr_d  = in_addr;
          dp_d    = OFS_LOW;
          dc_d    = OFS_LOW;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // walk pages inside columns: above, same, below
        if (dp_q == OFS_HIGH) begin
          dp_d = OFS_LOW;
          dc_d = dc_q + 2'd1;
          if (dc_q == OFS_HIGH) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dp_d = dp_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        strobe_d     = 1'b1;
        page_out_d   = 3'(page_q);
        column_out_d = 7'(col_q);
        next_byte_d  = result;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      page_q       <= '0;
      col_q        <= '0;
      addr_q       <= '0;
      dp_q         <= OFS_LOW;
      dc_q         <= OFS_LOW;
      strobe_q     <= 1'b0;
      page_out_q   <= '0;
      column_out_q <= '0;
      next_byte_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      page_q       <= page_d;
      col_q        <= col_d;
      addr_q       <= addr_d;
      dp_q         <= dp_d;
      dc_q         <= dc_d;
      strobe_q     <= strobe_d;
      page_out_q   <= page_out_d;
      column_out_q <= column_out_d;
      next_byte_q  <= next_byte_d;
    end
  end

  assign strobe_o     = strobe_q;
  assign page_out_o   = page_out_q;
  assign column_out_o = column_out_q;
  assign next_byte_o  = next_byte_q;

  // A result beat lands after the sequence has returned to idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobe while busy");

  // At most one result beat per compute item
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe on consecutive cycles");

  // A valid compute item holds the engine busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ng_re |=> busy && (state_q == ST_FETCH))
    else $error("compute item did not start fetch");

  // Frame store is written only by the clear sweep or an idle write item
  a_frame_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_we |-> (state_q == ST_CLEAR) || (state_q == ST_IDLE))
    else $error("frame store written mid-computation");

endmodule

// ===== tb/life_generation_byte_engine_test.sv =====
// Self-checking testbench for the life generation byte engine.
module life_generation_byte_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lgbe_pkg::*;

  localparam int unsigned COLS         = 128;
  localparam int unsigned PAGES        = 8;
  localparam int unsigned ROWS         = PAGES * ROWS_PER_PAGE;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned TIMEOUT_NS   = 1_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] kind_i;
  logic [2:0] page_i;
  logic [6:0] column_i;
  logic [7:0] data_i;
  logic       strobe_o;
  logic [2:0] page_out_o;
  logic [6:0] column_out_o;
  logic [7:0] next_byte_o;

  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    byte_t      value;
  } gen_byte_t;

  byte_t     frame_mem [PAGES*COLS];
  byte_t     next_mem  [PAGES*COLS];
  gen_byte_t pending_bytes [$];
  int        idle_pct;
  int        errors;

  life_generation_byte_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .page_i      (page_i),
    .column_i    (column_i),
    .data_i      (data_i),
    .strobe_o    (strobe_o),
    .page_out_o  (page_out_o),
    .column_out_o(column_out_o),
    .next_byte_o (next_byte_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cells beyond any frame edge are dead; no wrap.
  function automatic logic cell_alive(int x, int y);
    if (x < 0 || x >= COLS || y < 0 || y >= ROWS) return 1'b0;
    return frame_mem[(y / ROWS_PER_PAGE) * COLS + x][y % ROWS_PER_PAGE];
  endfunction

  function automatic byte_t evolve_byte(int pg, int col);
    byte_t acc;
    int    y;
    int    n;
    acc = next_mem[pg*COLS + col];
    for (int b = 0; b < ROWS_PER_PAGE; b++) begin
      y = pg * ROWS_PER_PAGE + b;
      n = 0;
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if (dx != 0 || dy != 0) n += int'(cell_alive(col + dx, y + dy));
      // survivors keep whatever the next-generation store already holds
      if (cell_alive(col, y)) begin
        if (n < 2 || n > 3) acc[b] = 1'b0;
      end else if (n == 3) begin
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(logic [1:0] kind, logic [2:0] pg, logic [6:0] col, byte_t data);
    gen_byte_t g;
    int        gap;
    @(negedge clk_i);
    start    <= 1'b1;
    kind_i   <= kind;
    page_i   <= pg;
    column_i <= col;
    data_i   <= data;
    do @(posedge clk_i); while (busy);
    case (kind)
      KIND_FRAME_WR: frame_mem[pg*COLS + col] = data;
      KIND_NEXT_WR:  next_mem[pg*COLS + col] = data;
      KIND_COMPUTE: begin
        g.page   = pg;
        g.column = col;
        g.value  = evolve_byte(pg, col);
        next_mem[pg*COLS + col] = g.value;
        pending_bytes.push_back(g);
      end
      default: ;
    endcase
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    gen_byte_t want;
    if (rst_ni && strobe_o) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected beat, next_byte", int'(next_byte_o), 0);
      end else begin
        want = pending_bytes.pop_front();
        if (page_out_o !== want.page)
          report_mismatch("page_out", int'(page_out_o), int'(want.page));
        if (column_out_o !== want.column)
          report_mismatch("column_out", int'(column_out_o), int'(want.column));
        if (next_byte_o !== want.value)
          report_mismatch("next_byte", int'(next_byte_o), int'(want.value));
      end
    end
  end

  // Fresh stores give zero bytes; the unused kind must leave no trace.
  task automatic test_after_reset();
    send_item(KIND_COMPUTE, 3'd0, 7'd0, 8'hFF);
    send_item(KIND_COMPUTE, 3'd7, 7'd127, 8'h00);
    send_item(KIND_UNUSED, 3'd3, 7'd64, 8'hFF);
    send_item(KIND_COMPUTE, 3'd3, 7'd64, 8'h00);
    send_item(KIND_COMPUTE, 3'd3, 7'd65, 8'h00);
  endtask

  // Corners, the page boundary and a full column.
  task automatic test_edges();
    send_item(KIND_FRAME_WR, 3'd0, 7'd0, 8'h03);
    send_item(KIND_FRAME_WR, 3'd0, 7'd1, 8'h03);
    send_item(KIND_COMPUTE, 3'd0, 7'd0, 8'h00);
    send_item(KIND_NEXT_WR, 3'd0, 7'd1, 8'hFF);
    send_item(KIND_COMPUTE, 3'd0, 7'd1, 8'h00);
    send_item(KIND_FRAME_WR, 3'd7, 7'd127, 8'hE0);
    send_item(KIND_COMPUTE, 3'd7, 7'd127, 8'h00);
    send_item(KIND_COMPUTE, 3'd7, 7'd126, 8'h00);
    send_item(KIND_FRAME_WR, 3'd3, 7'd20, 8'h80);
    send_item(KIND_FRAME_WR, 3'd4, 7'd20, 8'h01);
    send_item(KIND_FRAME_WR, 3'd3, 7'd21, 8'h80);
    send_item(KIND_COMPUTE, 3'd3, 7'd20, 8'h00);
    send_item(KIND_COMPUTE, 3'd4, 7'd21, 8'h00);
    send_item(KIND_FRAME_WR, 3'd5, 7'd64, 8'hFF);
    send_item(KIND_NEXT_WR, 3'd5, 7'd64, 8'h5A);
    send_item(KIND_COMPUTE, 3'd5, 7'd64, 8'hFF);
    send_item(KIND_COMPUTE, 3'd5, 7'd63, 8'h00);
  endtask

  // Most traffic clusters around a hotspot so neighbour counts get busy.
  task automatic test_random(int pct, int count);
    int         done;
    int         hot_pg;
    int         hot_col;
    int         pg;
    int         col;
    int         r;
    logic [1:0] kind;
    byte_t      data;
    idle_pct = pct;
    done     = 0;
    hot_pg   = $urandom_range(PAGES - 1);
    hot_col  = $urandom_range(COLS - 1);
    while (done < count) begin
      if ($urandom_range(31) == 0) begin
        hot_pg  = $urandom_range(PAGES - 1);
        hot_col = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : COLS - 1)
                                           : $urandom_range(COLS - 1);
      end
      r = $urandom_range(99);
      if (r < 40) kind = KIND_FRAME_WR;
      else if (r < 80) kind = KIND_COMPUTE;
      else if (r < 92) kind = KIND_NEXT_WR;
      else kind = KIND_UNUSED;
      if ($urandom_range(9) < 7) begin
        pg  = hot_pg + $urandom_range(2) - 1;
        col = hot_col + $urandom_range(4) - 2;
        if (pg < 0) pg = 0;
        if (pg > PAGES - 1) pg = PAGES - 1;
        if (col < 0) col = 0;
        if (col > COLS - 1) col = COLS - 1;
      end else begin
        pg  = $urandom_range(PAGES - 1);
        col = $urandom_range(COLS - 1);
      end
      data = byte_t'($urandom_range(255));
      if ($urandom_range(1)) data &= byte_t'($urandom_range(255));
      send_item(kind, pg[2:0], col[6:0], data);
      if (kind != KIND_UNUSED) done++;
    end
  endtask

  initial begin
    errors   = 0;
    idle_pct = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    kind_i   = KIND_FRAME_WR;
    page_i   = '0;
    column_i = '0;
    data_i   = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (next_mem[i]) next_mem[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_edges();
    test_random(36, 600);
    test_random(70, 600);
    test_random(0, 600);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lgbe_pkg.sv
hdl/lgbe_ram.sv
hdl/lgbe_count_unit.sv
hdl/life_generation_byte_engine.sv
tb/life_generation_byte_engine_test.sv
